### src/iwe_pkg.sv
package iwe_pkg;

  // verdict codes
  localparam logic [2:0] VERDICT_RUNNING  = 3'd0;
  localparam logic [2:0] VERDICT_MEASURED = 3'd1;
  localparam logic [2:0] VERDICT_LOWER    = 3'd2;
  localparam logic [2:0] VERDICT_MSS      = 3'd3;
  localparam logic [2:0] VERDICT_LIMIT    = 3'd4;
  localparam logic [2:0] VERDICT_REPLY    = 3'd5;

  // configuration register indexes
  localparam logic [1:0] REG_INITIAL_SEQ  = 2'd0;
  localparam logic [1:0] REG_MAX_SEGMENT  = 2'd1;
  localparam logic [1:0] REG_PACKET_LIMIT = 2'd2;

  localparam logic [15:0] MSS_RESET   = 16'd1460;
  localparam logic [15:0] LIMIT_RESET = 16'd100;
  localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

  // one quotient bit per step
  localparam int DIV_STEPS = 32;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

### src/iwe_div.sv
module iwe_div
  import iwe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output div_status_t status,
  output logic [31:0] quotient
);

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] count;
  logic [31:0]      dvd;
  logic [15:0]      rem;
  logic [15:0]      dsr;

  logic [16:0] trial;
  logic [16:0] diff;
  logic        ge;

  // restoring step: shift one dividend bit into the remainder
  assign trial = {rem, dvd[31]};
  assign diff  = trial - {1'b0, dsr};
  assign ge    = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      dvd <= {dvd[30:0], ge};
      rem <= ge ? diff[15:0] : trial[15:0];
    end
  end

  // round up on a nonzero remainder; quotient of all ones only with divisor 0 or 1
  assign quotient    = dvd + {31'b0, (rem != 16'd0)};
  assign status.busy = busy;
  assign status.done = done;

endmodule

### src/initial_window_estimator.sv
// States run S_IDLE, S_EVAL, S_BYTES, then S_OUT holds the result; when a
//   window must be divided out, S_DIV waits on the divider (32 quotient steps).
// One segment at a time: in_stall stays high until the result
//   transfer completes.
// Reset (rst, synchronous): registers to 0 / MSS 1460 / limit 100, test state
//   cleared, block idle and ready.
module initial_window_estimator
  import iwe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // config write port
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [31:0] wr_data,
  // segment input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] seq_number,
  input  logic [15:0] payload_len,
  input  logic        fin_seen,
  input  logic        reply_ok,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  verdict,
  output logic [31:0] window_packets,
  output logic [31:0] bytes_seen
);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for a segment
  localparam logic [2:0] S_EVAL  = 3'd1;  // checks and state update
  localparam logic [2:0] S_BYTES = 3'd2;  // bytes seen, launch divide if needed
  localparam logic [2:0] S_DIV   = 3'd3;  // waiting on divider
  localparam logic [2:0] S_OUT   = 3'd4;  // result held until transfer

  logic [2:0] state;

  // config registers
  logic [31:0] initial_seq;
  logic [15:0] max_segment;
  logic [15:0] packet_limit;

  // test state
  logic [15:0] largest_payload;
  logic [31:0] highest_seq;
  logic [15:0] data_packet_count;
  logic        test_done;
  logic [2:0]  final_verdict;
  logic [31:0] final_window;
  logic        div_needed;

  // captured segment
  logic [31:0] seq_r;
  logic [15:0] len_r;
  logic        fin_r;
  logic        ok_r;

  logic [31:0] bytes_r;

  logic in_xfer;
  logic out_xfer;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;

  // ---------------------------------------------------------------------------
  // Segment evaluation (S_EVAL), in the model's order: reply error, MSS,
  // then payload/count/highest update; FIN and packet limit afterwards.
  // ---------------------------------------------------------------------------
  logic [31:0] rel_seq;
  logic [31:0] end_seq;
  logic [15:0] largest_next;
  logic [15:0] count_next;
  logic [31:0] highest_next;
  logic        done_next;
  logic [2:0]  verdict_next;

  assign rel_seq = seq_r - initial_seq;
  assign end_seq = seq_r + {16'b0, len_r} - 32'd1;

  always_comb begin
    largest_next = largest_payload;
    count_next   = data_packet_count;
    highest_next = highest_seq;
    done_next    = test_done;
    verdict_next = final_verdict;
    if (!test_done && (len_r != 16'd0)) begin
      if ((rel_seq == 32'd1) && !ok_r) begin
        done_next    = 1'b1;
        verdict_next = VERDICT_REPLY;
      end else if (len_r > max_segment) begin
        done_next    = 1'b1;
        verdict_next = VERDICT_MSS;
      end else begin
        if (len_r > largest_payload) begin
          largest_next = len_r;
        end
        if (data_packet_count != COUNT_MAX) begin
          count_next = data_packet_count + 16'd1;
        end
        if (end_seq > highest_seq) begin
          highest_next = end_seq;
        end else begin
          // retransmission
          done_next    = 1'b1;
          verdict_next = VERDICT_MEASURED;
        end
      end
    end
    if (!done_next) begin
      if (fin_r) begin
        done_next    = 1'b1;
        verdict_next = VERDICT_LOWER;
      end else if (count_next >= packet_limit) begin
        done_next    = 1'b1;
        verdict_next = VERDICT_LIMIT;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Divider: ceil(bytes / largest_payload)
  // ---------------------------------------------------------------------------
  logic [31:0] bytes_now;
  logic        div_start;
  div_status_t div_stat;
  logic [31:0] div_quot;

  assign bytes_now = highest_seq - initial_seq;
  assign div_start = (state == S_BYTES) && div_needed && (largest_payload != 16'd0);

  iwe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (bytes_now),
    .divisor  (largest_payload),
    .status   (div_stat),
    .quotient (div_quot)
  );

  // ---------------------------------------------------------------------------
  // Sequencer and state registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      initial_seq       <= '0;
      max_segment       <= MSS_RESET;
      packet_limit      <= LIMIT_RESET;
      largest_payload   <= '0;
      highest_seq       <= '0;
      data_packet_count <= '0;
      test_done         <= 1'b0;
      final_verdict     <= VERDICT_RUNNING;
      final_window      <= '0;
      div_needed        <= 1'b0;
    end else begin
      // config writes take effect at once; user must issue them only with no segment in flight (not enforced)
      if (wr_en) begin
        case (wr_index)
          REG_INITIAL_SEQ: begin
            initial_seq <= wr_data;
            highest_seq <= wr_data;
          end
          REG_MAX_SEGMENT:  max_segment  <= wr_data[15:0];
          REG_PACKET_LIMIT: packet_limit <= wr_data[15:0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          largest_payload   <= largest_next;
          data_packet_count <= count_next;
          highest_seq       <= highest_next;
          div_needed        <= 1'b0;
          if (done_next && !test_done) begin
            test_done     <= 1'b1;
            final_verdict <= verdict_next;
            final_window  <= '0;
            div_needed    <= (verdict_next == VERDICT_MEASURED) ||
                             (verdict_next == VERDICT_LOWER);
          end
          state <= S_BYTES;
        end
        S_BYTES: begin
          // zero largest payload leaves the window at 0
          state <= div_start ? S_DIV : S_OUT;
        end
        S_DIV: begin
          if (div_stat.done) begin
            final_window <= div_quot;
            state        <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_xfer) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload captures
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      seq_r <= seq_number;
      len_r <= payload_len;
      fin_r <= fin_seen;
      ok_r  <= reply_ok;
    end
    if (state == S_BYTES) begin
      bytes_r <= bytes_now;
    end
  end

  // verdict/window registers stay 0 until the test finishes
  assign verdict        = final_verdict;
  assign window_packets = final_window;
  assign bytes_seen     = bytes_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_div_only_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> (state == S_DIV))
    else $error("divider busy outside divide state");

  a_done_rises_in_eval: assert property (@(posedge clk) disable iff (rst)
    $rose(test_done) |-> ($past(state) == S_EVAL))
    else $error("test_done set outside evaluation");

  a_verdict_needs_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (verdict != VERDICT_RUNNING)) |-> test_done)
    else $error("final verdict reported while test running");

  a_window_only_measured: assert property (@(posedge clk) disable iff (rst)
    (window_packets != 32'd0) |->
      ((verdict == VERDICT_MEASURED) || (verdict == VERDICT_LOWER)))
    else $error("window reported with a verdict that carries none");

endmodule
